/* src/tdrwc_pkg.sv */
// Shared types and constants of the TDC readout word checker.
package tdrwc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BoardW    = 4;
  localparam int unsigned FlagW     = 10;
  localparam int unsigned TrayW     = 7;
  localparam int unsigned PhaseW    = 12;
  localparam int unsigned CountW    = 12;
  localparam int unsigned HalfW     = 8;
  localparam int unsigned RepW      = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InUserW   = 5;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned OutUserW  = 3;

  localparam logic [3:0]        NibGeo   = 4'hC;
  localparam logic [3:0]        NibHdr   = 4'h2;
  localparam logic [3:0]        NibSep   = 4'hE;
  localparam logic [3:0]        NibTrg   = 4'hA;
  localparam logic [3:0]        NibData0 = 4'h4;
  localparam logic [3:0]        NibData1 = 4'h5;
  localparam logic [3:0]        NibTerr  = 4'h6;
  localparam logic [WordW-1:0]  TagWord  = 32'hDEAD_FACE;
  localparam logic [23:0]       GeoUpper = 24'hC0_0000;
  localparam logic [7:0]        HdrTop   = 8'h20;
  localparam logic [RepW-1:0]   LongRep  = 10'd1022;
  localparam logic [CountW-1:0] LongCnt  = 12'd1021;
  localparam logic [CountW-1:0] CountMax = 12'hFFF;
  localparam logic [HalfW-1:0]  HalfMax  = 8'hFF;

  // error flag bit positions
  localparam int unsigned FlgRepeat = 0;
  localparam int unsigned FlgBitErr = 1;
  localparam int unsigned FlgHalf   = 2;
  localparam int unsigned FlgSep    = 3;
  localparam int unsigned FlgHdr    = 4;
  localparam int unsigned FlgGeo    = 5;
  localparam int unsigned FlgPhase  = 6;
  localparam int unsigned FlgCount  = 7;
  localparam int unsigned FlgTdcErr = 8;
  localparam int unsigned FlgUnexp  = 9;

  localparam logic [BoardW-1:0] Board1 = 4'd1;
  localparam logic [BoardW-1:0] Board2 = 4'd2;
  localparam logic [BoardW-1:0] Board3 = 4'd3;
  localparam logic [BoardW-1:0] Board4 = 4'd4;
  localparam logic [TrayW-1:0]  TrayExc0 = 7'd121;
  localparam logic [TrayW-1:0]  TrayExc1 = 7'd122;

  localparam logic [CfgIdxW-1:0] RegExp1 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExp2 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegExp3 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegExp4 = 2'd3;

  typedef enum logic [2:0] {
    CLS_GEO  = 3'd0,
    CLS_HDR  = 3'd1,
    CLS_SEP  = 3'd2,
    CLS_TRG  = 3'd3,
    CLS_TAG  = 3'd4,
    CLS_DATA = 3'd5,
    CLS_TERR = 3'd6,
    CLS_UNEX = 3'd7
  } word_class_e;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [BoardW-1:0] board;
    logic              first_of_block;
    logic              last_of_block;
  } in_item_t;

  typedef struct packed {
    word_class_e       cls;
    logic [TrayW-1:0]  tray;
    logic              half;
    logic [PhaseW-1:0] phase;
    logic [RepW-1:0]   rep;
    logic              hdr_top_ok;
    logic              geo_bit_err;
  } decode_t;

  typedef struct packed {
    word_class_e       word_class;
    logic [FlagW-1:0]  error_flags;
    logic [TrayW-1:0]  geo_tray;
    logic              geo_half;
    logic [PhaseW-1:0] phase_offset;
    logic              phase_offset_valid;
    logic [CountW-1:0] actual_count;
    logic [HalfW-1:0]  half_count;
    logic              half_count_wrong;
    logic              summary_valid;
  } result_t;

endpackage

/* src/tdrwc_decode.sv */
// Word classifier and field extraction.
module tdrwc_decode (
  input  logic [tdrwc_pkg::WordW-1:0] word_i,
  output tdrwc_pkg::decode_t          dec_o
);
  import tdrwc_pkg::*;

  logic [3:0] nib;

  assign nib = word_i[31:28];

  always_comb begin
    if (nib == NibGeo) begin
      dec_o.cls = CLS_GEO;
    end else if (nib == NibHdr) begin
      dec_o.cls = CLS_HDR;
    end else if (nib == NibSep) begin
      dec_o.cls = CLS_SEP;
    end else if (nib == NibTrg) begin
      dec_o.cls = CLS_TRG;
    end else if (word_i == TagWord) begin
      dec_o.cls = CLS_TAG;
    end else if (nib == NibData0 || nib == NibData1) begin
      dec_o.cls = CLS_DATA;
    end else if (nib == NibTerr) begin
      dec_o.cls = CLS_TERR;
    end else begin
      dec_o.cls = CLS_UNEX;
    end
    dec_o.tray        = word_i[7:1];
    dec_o.half        = word_i[0];
    dec_o.phase       = word_i[PhaseW-1:0];
    dec_o.rep         = word_i[17:8];
    dec_o.hdr_top_ok  = (word_i[31:24] == HdrTop);
    dec_o.geo_bit_err = (word_i[31:8] != GeoUpper);
  end

endmodule

/* src/tdrwc_core.sv */
// Block state, per-word checks and expected-count registers.
module tdrwc_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           cfg_we_i,
  input  logic [tdrwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tdrwc_pkg::CfgDataW-1:0] cfg_data_i,
  input  tdrwc_pkg::in_item_t            item_i,
  input  tdrwc_pkg::decode_t             dec_i,
  output tdrwc_pkg::result_t             res_o
);
  import tdrwc_pkg::*;

  logic [HalfW-1:0]  exp1_q, exp2_q, exp3_q, exp4_q;
  logic              parity_q, parity_d;
  logic [12:0]       ref_phase_q, ref_phase_d;
  logic [WordW-1:0]  prev_q, prev_b;
  logic [CountW-1:0] ism_q, ism_b, ism_inc, ism_d;
  logic [HalfW-1:0]  hs_q, hs_b, hs_d;
  logic [TrayW-1:0]  tray_q, tray_b, tray_d;
  logic              hexp_q, hexp_b, hexp_d;
  logic              sexp_q, sexp_b, sexp_d;
  logic              await_q, await_b, await_d;
  logic [PhaseW-1:0] bph_q, bph_b, bph_d;
  logic [HalfW-1:0]  exp_sel;
  logic              board_known;

  always_comb begin
    ism_b   = item_i.first_of_block ? '0 : ism_q;
    prev_b  = item_i.first_of_block ? '1 : prev_q;
    hs_b    = item_i.first_of_block ? '0 : hs_q;
    tray_b  = item_i.first_of_block ? '0 : tray_q;
    hexp_b  = item_i.first_of_block ? 1'b0 : hexp_q;
    sexp_b  = item_i.first_of_block ? 1'b0 : sexp_q;
    await_b = item_i.first_of_block ? 1'b1 : await_q;
    bph_b   = item_i.first_of_block ? '0 : bph_q;
    ism_inc = (ism_b != CountMax) ? ism_b + 12'd1 : ism_b;

    ism_d       = ism_inc;
    hs_d        = hs_b;
    tray_d      = tray_b;
    hexp_d      = hexp_b;
    sexp_d      = sexp_b;
    await_d     = await_b;
    bph_d       = bph_b;
    parity_d    = parity_q;
    ref_phase_d = ref_phase_q;

    res_o = '0;
    res_o.word_class = dec_i.cls;
    res_o.error_flags[FlgRepeat] = (item_i.word == prev_b);

    case (dec_i.cls)
      CLS_GEO: begin
        ism_d          = '0;
        res_o.geo_tray = dec_i.tray;
        res_o.geo_half = dec_i.half;
        res_o.error_flags[FlgBitErr] = dec_i.geo_bit_err;
        res_o.error_flags[FlgHalf]   = (dec_i.half == parity_q);
        res_o.error_flags[FlgSep]    = sexp_b;
        parity_d = dec_i.half;
        hexp_d   = 1'b1;
        sexp_d   = 1'b1;
        tray_d   = dec_i.tray;
        hs_d     = (hs_b != HalfMax) ? hs_b + 8'd1 : hs_b;
      end
      CLS_HDR: begin
        if (await_b) begin
          bph_d = dec_i.phase;
          if (item_i.board == Board1) begin
            ref_phase_d = {1'b1, dec_i.phase};
          end else begin
            res_o.phase_offset       = ref_phase_q[PhaseW-1:0] - dec_i.phase;
            res_o.phase_offset_valid = 1'b1;
          end
          await_d = 1'b0;
        end else if (tray_b != TrayExc0 && tray_b != TrayExc1) begin
          res_o.error_flags[FlgPhase] = (dec_i.phase != bph_b);
        end
        res_o.error_flags[FlgGeo] = !hexp_b && dec_i.hdr_top_ok;
        hexp_d = 1'b0;
      end
      CLS_SEP: begin
        res_o.actual_count = ism_inc - 12'd1;
        sexp_d = 1'b0;
        if (hexp_b) begin
          res_o.error_flags[FlgHdr] = 1'b1;
          hexp_d = 1'b0;
        end else if (!(dec_i.rep == LongRep && ism_inc == LongCnt)) begin
          res_o.error_flags[FlgCount] = ({2'b00, dec_i.rep} != res_o.actual_count);
        end
        ism_d = '0;
      end
      CLS_TRG: begin
        ism_d = '0;
        res_o.error_flags[FlgHalf] = parity_q;
        res_o.error_flags[FlgSep]  = sexp_b;
        res_o.error_flags[FlgHdr]  = hexp_b;
        parity_d = 1'b0;
        sexp_d   = 1'b0;
        hexp_d   = 1'b0;
      end
      CLS_TAG:  ism_d = '0;
      CLS_DATA: ;
      CLS_TERR: res_o.error_flags[FlgTdcErr] = 1'b1;
      default:  res_o.error_flags[FlgUnexp] = 1'b1;
    endcase

    board_known = 1'b1;
    case (item_i.board)
      Board1:  exp_sel = exp1_q;
      Board2:  exp_sel = exp2_q;
      Board3:  exp_sel = exp3_q;
      Board4:  exp_sel = exp4_q;
      default: begin
        exp_sel     = '0;
        board_known = 1'b0;
      end
    endcase

    res_o.half_count       = hs_d;
    res_o.summary_valid    = item_i.last_of_block;
    res_o.half_count_wrong = item_i.last_of_block && board_known && (hs_d != exp_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp1_q      <= 8'd60;
      exp2_q      <= 8'd62;
      exp3_q      <= 8'd60;
      exp4_q      <= 8'd58;
      parity_q    <= 1'b0;
      ref_phase_q <= '0;
      prev_q      <= '1;
      ism_q       <= '0;
      hs_q        <= '0;
      tray_q      <= '0;
      hexp_q      <= 1'b0;
      sexp_q      <= 1'b0;
      await_q     <= 1'b1;
      bph_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegExp1: exp1_q <= cfg_data_i;
          RegExp2: exp2_q <= cfg_data_i;
          RegExp3: exp3_q <= cfg_data_i;
          RegExp4: exp4_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (en_i) begin
        parity_q    <= parity_d;
        ref_phase_q <= ref_phase_d;
        prev_q      <= item_i.word;
        ism_q       <= ism_d;
        hs_q        <= hs_d;
        tray_q      <= tray_d;
        hexp_q      <= hexp_d;
        sexp_q      <= sexp_d;
        await_q     <= await_d;
        bph_q       <= bph_d;
      end
    end
  end

endmodule

/* src/tdrwc_out_reg.sv */
// Result register on the master side.
module tdrwc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tdrwc_pkg::result_t  res_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tdrwc_pkg::result_t  res_o
);
  import tdrwc_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* src/tdc_readout_word_checker_unit.sv */
// Top level of the TDC readout word checker.
//
//   channel   dir  fields
//   s_axis    in   tdata: word | tuser: board, first_of_block | tlast: last_of_block
//   m_axis    out  tdata: flags, tray, half, offset, offset valid, count, halves,
//                  halves wrong | tuser: word_class | tlast: summary_valid
//   cfg       in   expected half counts of boards 1 to 4, index 0 to 3
//
// One item per clock unless the master side stalls; input register, then result register.
// All checks sit in one combinational pass between the two registers.
// Reset clears block state as a block start would; expected counts return to defaults.
// A stalled master side holds one result and one item, then tready drops.
module tdc_readout_word_checker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tdrwc_pkg::WordW-1:0]    s_axis_tdata_i,  // [31:0] word
  input  logic [tdrwc_pkg::InUserW-1:0]  s_axis_tuser_i,  // [3:0] board, [4] first_of_block
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [9:0] error_flags, [16:10] geo_tray, [17] geo_half, [29:18] phase_offset,
  // [30] phase_offset_valid, [42:31] actual_count, [50:43] half_count,
  // [51] half_count_wrong, [55:52] zero
  output logic [tdrwc_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [tdrwc_pkg::OutUserW-1:0] m_axis_tuser_o,  // [2:0] word_class
  output logic                           m_axis_tlast_o,
  input  logic                           cfg_we_i,
  input  logic [tdrwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tdrwc_pkg::CfgDataW-1:0] cfg_data_i
);
  import tdrwc_pkg::*;

  logic     in_valid_q;
  in_item_t in_q;
  logic     out_ready;
  logic     advance;
  decode_t  dec;
  result_t  res, res_out;

  assign advance         = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.word           <= s_axis_tdata_i;
      in_q.board          <= s_axis_tuser_i[3:0];
      in_q.first_of_block <= s_axis_tuser_i[4];
      in_q.last_of_block  <= s_axis_tlast_i;
    end
  end

  tdrwc_decode u_decode (
    .word_i (in_q.word),
    .dec_o  (dec)
  );

  tdrwc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_q),
    .dec_i      (dec),
    .res_o      (res)
  );

  tdrwc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (out_ready),
    .res_i   (res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = {4'b0000,
                           res_out.half_count_wrong,
                           res_out.half_count,
                           res_out.actual_count,
                           res_out.phase_offset_valid,
                           res_out.phase_offset,
                           res_out.geo_half,
                           res_out.geo_tray,
                           res_out.error_flags};
  assign m_axis_tuser_o = res_out.word_class;
  assign m_axis_tlast_o = res_out.summary_valid;

endmodule

/* src/tdrwc_checker.sv */
// Port-level assertions for the TDC readout word checker, bound to the top level.
module tdrwc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [tdrwc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [tdrwc_pkg::OutUserW-1:0] m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import tdrwc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_terr_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == CLS_TERR |-> m_axis_tdata_o[FlgTdcErr])
    else $error("tdc error item without flag");

  a_geo_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != CLS_GEO |-> m_axis_tdata_o[17:10] == '0)
    else $error("tray fields on non-geographic item");

  a_wrong_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[51] |-> m_axis_tlast_o)
    else $error("half count verdict outside block end");

endmodule

bind tdc_readout_word_checker_unit tdrwc_checker u_tdrwc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* verif/tb_tdc_readout_word_checker_unit.sv */
`timescale 1ns / 100ps
// Self-checking bench for the TDC readout word checker: block-structured word streams under random flow control.
module tb;
  import tdrwc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportCap  = 200;

  class word_check_model;
    logic [HalfW-1:0]  exp_halves [4];
    logic              half_parity;
    logic [12:0]       ref_phase;
    logic [WordW-1:0]  prev_word;
    logic [CountW-1:0] since_mark;
    logic [HalfW-1:0]  halves_seen;
    logic [TrayW-1:0]  cur_tray;
    logic              hdr_pending;
    logic              sep_pending;
    logic              await_hdr;
    logic [PhaseW-1:0] block_phase;
    result_t           pending_verdicts [$];
    int unsigned       fails;
    int unsigned       checked;
    int unsigned       summaries;
    logic [7:0]        classes_seen;
    logic [FlagW-1:0]  flags_seen;

    function void clear_block();
      prev_word   = '1;
      since_mark  = '0;
      halves_seen = '0;
      cur_tray    = '0;
      hdr_pending = 1'b0;
      sep_pending = 1'b0;
      await_hdr   = 1'b1;
      block_phase = '0;
    endfunction

    function void power_up();
      exp_halves[0] = 8'd60;
      exp_halves[1] = 8'd62;
      exp_halves[2] = 8'd60;
      exp_halves[3] = 8'd58;
      half_parity   = 1'b0;
      ref_phase     = '0;
      fails         = 0;
      checked       = 0;
      summaries     = 0;
      classes_seen  = '0;
      flags_seen    = '0;
      clear_block();
    endfunction

    function void set_expected(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      exp_halves[idx] = val;
    endfunction

    function void note_word(in_item_t it);
      logic [WordW-1:0]  w;
      logic [PhaseW-1:0] ph;
      logic [RepW-1:0]   rep;
      result_t           r;
      w = it.word;
      r = '0;
      if (it.first_of_block) clear_block();
      if (since_mark != CountMax) since_mark++;
      if (w == prev_word) r.error_flags[FlgRepeat] = 1'b1;
      prev_word = w;
      if (w == TagWord) begin
        r.word_class = CLS_TAG;
        since_mark = '0;
      end else begin
        case (w[31:28])
          NibGeo: begin
            r.word_class = CLS_GEO;
            since_mark = '0;
            r.geo_tray = w[7:1];
            r.geo_half = w[0];
            if (w[31:8] != GeoUpper) r.error_flags[FlgBitErr] = 1'b1;
            if (w[0] == half_parity) r.error_flags[FlgHalf] = 1'b1;
            half_parity = w[0];
            if (sep_pending) r.error_flags[FlgSep] = 1'b1;
            hdr_pending = 1'b1;
            sep_pending = 1'b1;
            cur_tray = w[7:1];
            if (halves_seen != HalfMax) halves_seen++;
          end
          NibHdr: begin
            ph = w[11:0];
            r.word_class = CLS_HDR;
            if (await_hdr) begin
              block_phase = ph;
              if (it.board == Board1) begin
                ref_phase = {1'b1, ph};
              end else begin
                r.phase_offset = ref_phase[11:0] - ph;
                r.phase_offset_valid = 1'b1;
              end
              await_hdr = 1'b0;
            end else if (cur_tray != TrayExc0 && cur_tray != TrayExc1 && ph != block_phase) begin
              r.error_flags[FlgPhase] = 1'b1;
            end
            if (!hdr_pending && w[31:24] == HdrTop) r.error_flags[FlgGeo] = 1'b1;
            hdr_pending = 1'b0;
          end
          NibSep: begin
            rep = w[17:8];
            r.word_class = CLS_SEP;
            r.actual_count = since_mark - 12'd1;
            sep_pending = 1'b0;
            if (hdr_pending) begin
              r.error_flags[FlgHdr] = 1'b1;
              hdr_pending = 1'b0;
            end else if (!(rep == LongRep && since_mark == LongCnt)
                         && {2'b00, rep} != r.actual_count) begin
              r.error_flags[FlgCount] = 1'b1;
            end
            since_mark = '0;
          end
          NibTrg: begin
            r.word_class = CLS_TRG;
            since_mark = '0;
            if (half_parity) r.error_flags[FlgHalf] = 1'b1;
            half_parity = 1'b0;
            if (sep_pending) r.error_flags[FlgSep] = 1'b1;
            if (hdr_pending) r.error_flags[FlgHdr] = 1'b1;
            sep_pending = 1'b0;
            hdr_pending = 1'b0;
          end
          NibData0, NibData1: r.word_class = CLS_DATA;
          NibTerr: begin
            r.word_class = CLS_TERR;
            r.error_flags[FlgTdcErr] = 1'b1;
          end
          default: begin
            r.word_class = CLS_UNEX;
            r.error_flags[FlgUnexp] = 1'b1;
          end
        endcase
      end
      r.half_count = halves_seen;
      if (it.last_of_block) begin
        r.summary_valid = 1'b1;
        if (it.board >= Board1 && it.board <= Board4)
          r.half_count_wrong = (halves_seen != exp_halves[2'(it.board - Board1)]);
      end
      pending_verdicts.push_back(r);
    endfunction

    function void report(string msg);
      fails++;
      // cap the log on a badly broken block; failures are still counted
      if (fails <= ReportCap) $error("%s", msg);
    endfunction

    function void cmp(string field, int unsigned want, int unsigned seen);
      if (want != seen)
        report($sformatf("%s: expected 0x%0h, got 0x%0h", field, want, seen));
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("word_class: expected nothing, got 0x%0h", got.word_class));
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      classes_seen[got.word_class] = 1'b1;
      flags_seen |= got.error_flags;
      if (got.summary_valid) summaries++;
      cmp("word_class", want.word_class, got.word_class);
      cmp("error_flags", want.error_flags, got.error_flags);
      cmp("geo_tray", want.geo_tray, got.geo_tray);
      cmp("geo_half", want.geo_half, got.geo_half);
      cmp("phase_offset", want.phase_offset, got.phase_offset);
      cmp("phase_offset_valid", want.phase_offset_valid, got.phase_offset_valid);
      cmp("actual_count", want.actual_count, got.actual_count);
      cmp("half_count", want.half_count, got.half_count);
      cmp("half_count_wrong", want.half_count_wrong, got.half_count_wrong);
      cmp("summary_valid", want.summary_valid, got.summary_valid);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [WordW-1:0]    s_axis_tdata_i = '0;
  logic [InUserW-1:0]  s_axis_tuser_i = '0;
  logic                s_axis_tlast_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  word_check_model chk;
  bit              tx_idle_on = 1'b1;
  bit              rx_idle_on = 1'b1;
  int unsigned     rx_hold_req = 0;
  int unsigned     rx_hold_left = 0;
  int unsigned     n_sent = 0;
  int unsigned     cycle_cnt = 0;
  logic [WordW-1:0] prev_sent = '0;

  tdc_readout_word_checker_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always begin : rx_side
    result_t got;
    @(posedge clk_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.word_class         = word_class_e'(m_axis_tuser_o[2:0]);
      got.error_flags        = m_axis_tdata_o[9:0];
      got.geo_tray           = m_axis_tdata_o[16:10];
      got.geo_half           = m_axis_tdata_o[17];
      got.phase_offset       = m_axis_tdata_o[29:18];
      got.phase_offset_valid = m_axis_tdata_o[30];
      got.actual_count       = m_axis_tdata_o[42:31];
      got.half_count         = m_axis_tdata_o[50:43];
      got.half_count_wrong   = m_axis_tdata_o[51];
      got.summary_valid      = m_axis_tlast_o;
      chk.check_word(got);
    end
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rx_idle_on ? ($urandom_range(99) >= 34) : 1'b1;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tdc_readout_word_checker_unit: mismatch");
    $finish;
  end

  task automatic send(input logic [WordW-1:0] w, input logic [BoardW-1:0] board,
                      input bit first, input bit last);
    in_item_t it;
    it.word = w;
    it.board = board;
    it.first_of_block = first;
    it.last_of_block = last;
    if (tx_idle_on && $urandom_range(99) < 34) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    s_axis_tuser_i  <= {first, board};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    chk.note_word(it);
    prev_sent = w;
    n_sent++;
  endtask

  // sender stops and waits for every result before anything else happens
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (chk.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    chk.set_expected(idx, val);
  endtask

  task automatic set_cfg(input logic [CfgDataW-1:0] e1, e2, e3, e4);
    write_reg(RegExp1, e1);
    write_reg(RegExp2, e2);
    write_reg(RegExp3, e3);
    write_reg(RegExp4, e4);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] noise_word();
    logic [WordW-1:0] w;
    w = $urandom;
    case ($urandom_range(10))
      0: w[31:28] = NibGeo;
      1: w[31:28] = NibHdr;
      2: w[31:28] = NibSep;
      3: w[31:28] = NibTrg;
      4: w = TagWord;
      5: w[31:28] = $urandom_range(1) ? NibData0 : NibData1;
      6: w[31:28] = NibTerr;
      7: w = prev_sent;
      8: w = {GeoUpper, 8'($urandom)};
      9: w = {HdrTop, 24'($urandom)};
      default: ;
    endcase
    return w;
  endfunction

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(8, 1);
    repeat (n)
      send(noise_word(), 4'($urandom_range(15)), $urandom_range(15) == 0,
           $urandom_range(7) == 0);
  endtask

  task automatic sane_block();
    logic [BoardW-1:0] board;
    logic [PhaseW-1:0] ph;
    logic [TrayW-1:0]  tray;
    logic [WordW-1:0]  w;
    logic [RepW-1:0]   rep;
    int unsigned       nh;
    int unsigned       nd;
    bit                mark_first;
    bit                mark_last;
    bit                half;
    bit                had_hdr;
    bit                is_end;
    board = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4, 1));
    nh = $urandom_range(8);
    if (board >= Board1 && board <= Board4 && $urandom_range(2) == 0
        && chk.exp_halves[2'(board - Board1)] <= 40)
      nh = 32'(chk.exp_halves[2'(board - Board1)]);
    mark_first = $urandom_range(19) != 0;
    mark_last  = $urandom_range(19) != 0;
    ph = 12'($urandom);
    send({NibTrg, 28'($urandom)}, board, mark_first, mark_last && nh == 0);
    half = 1'b1;
    for (int h = 0; h < nh; h++) begin
      is_end = (h == nh - 1);
      if ($urandom_range(12) == 0) send(noise_word(), board, 1'b0, 1'b0);
      tray = 7'($urandom);
      if ($urandom_range(7) == 0) tray = $urandom_range(1) ? TrayExc0 : TrayExc1;
      w = {GeoUpper, tray, half};
      if ($urandom_range(15) == 0) w[27:8] = 20'($urandom);
      send(w, board, 1'b0, 1'b0);
      half = ~half;
      had_hdr = $urandom_range(15) != 0;
      if (had_hdr) begin
        w = {HdrTop, 12'($urandom), ($urandom_range(11) == 0) ? 12'($urandom) : ph};
        if ($urandom_range(15) == 0) w[27:24] = 4'($urandom);
        send(w, board, 1'b0, 1'b0);
      end
      nd = $urandom_range(5);
      repeat (nd)
        send({$urandom_range(1) ? NibData0 : NibData1, 28'($urandom)}, board, 1'b0, 1'b0);
      rep = 10'(nd + had_hdr);
      if ($urandom_range(11) == 0) rep = 10'($urandom);
      if (is_end || $urandom_range(19) != 0)
        send({NibSep, 10'($urandom), rep, 8'($urandom)}, board, 1'b0, mark_last && is_end);
    end
  endtask

  task automatic random_blocks(input int unsigned upto);
    while (n_sent < upto) begin
      if ($urandom_range(99) < 80) sane_block();
      else noise_burst();
    end
  endtask

  task automatic directed();
    send({NibTrg, 28'h0}, Board1, 1'b1, 1'b0);
    send({GeoUpper, 7'd0, 1'b1}, Board1, 1'b0, 1'b0);
    send({HdrTop, 12'h000, 12'hFFF}, Board1, 1'b0, 1'b0);
    send(32'h4000_0000, Board1, 1'b0, 1'b0);
    send(32'h5FFF_FFFF, Board1, 1'b0, 1'b0);
    send({NibSep, 10'h0, 10'd3, 8'h00}, Board1, 1'b0, 1'b0);
    // exempt tray: off phase tolerated
    send({GeoUpper, TrayExc1, 1'b0}, Board1, 1'b0, 1'b0);
    send({HdrTop, 24'h00_0000}, Board1, 1'b0, 1'b0);
    send({NibSep, 10'h3FF, 10'h3FF, 8'hFF}, Board1, 1'b0, 1'b0);
    send(32'hCFFF_FFFF, Board1, 1'b0, 1'b0);
    send(32'hCFFF_FFFF, Board1, 1'b0, 1'b0);
    send(32'h2100_0ABC, Board1, 1'b0, 1'b0);
    send(32'h2000_0123, Board1, 1'b0, 1'b0);
    send(TagWord, Board1, 1'b0, 1'b0);
    send({NibTerr, 28'h000_0001}, Board1, 1'b0, 1'b0);
    send(32'h0000_0000, Board1, 1'b0, 1'b0);
    send(32'hFFFF_FFFF, Board1, 1'b0, 1'b0);
    send(32'hD000_0000, Board1, 1'b0, 1'b0);
    // trigger while header and separator still owed
    send({GeoUpper, 7'd1, 1'b0}, Board1, 1'b0, 1'b0);
    send({NibTrg, 28'hFFF_FFFF}, Board1, 1'b0, 1'b0);
    send({GeoUpper, 7'd2, 1'b1}, Board1, 1'b0, 1'b0);
    send({NibSep, 28'h0}, Board1, 1'b0, 1'b1);
    send({NibTrg, 28'h123_4567}, Board2, 1'b1, 1'b0);
    send({HdrTop, 12'hABC, 12'h001}, Board2, 1'b0, 1'b0);
    send(32'h5000_0000, Board2, 1'b0, 1'b1);
    send({NibTrg, 28'h1}, 4'd0, 1'b1, 1'b1);
    send({NibTrg, 28'h2}, 4'd15, 1'b1, 1'b1);
  endtask

  task automatic long_runs();
    logic half;
    // separator after 1020 counted items reported as 1022
    send({NibTrg, 28'h0}, Board3, 1'b1, 1'b0);
    send({GeoUpper, 7'd5, 1'b1}, Board3, 1'b0, 1'b0);
    send({HdrTop, 12'h0, 12'h155}, Board3, 1'b0, 1'b0);
    repeat (1019) send({NibData0, 28'($urandom)}, Board3, 1'b0, 1'b0);
    send({NibSep, 10'h0, LongRep, 8'h0}, Board3, 1'b0, 1'b0);
    // item counter runs into its ceiling
    send({GeoUpper, 7'd6, 1'b0}, Board3, 1'b0, 1'b0);
    send({HdrTop, 12'h0, 12'h155}, Board3, 1'b0, 1'b0);
    repeat (4100) send({NibData1, 28'($urandom)}, Board3, 1'b0, 1'b0);
    send({NibSep, 10'($urandom), 10'($urandom), 8'($urandom)}, Board3, 1'b0, 1'b1);
    // half counter runs into its ceiling
    send({NibTrg, 28'h0}, Board2, 1'b1, 1'b0);
    half = 1'b1;
    for (int i = 0; i < 260; i++) begin
      send({GeoUpper, 7'(i), half}, Board2, 1'b0, i == 259);
      half = ~half;
    end
  endtask

  initial begin
    chk = new;
    chk.power_up();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    settle();
    set_cfg(8'd0, 8'd255, 8'd0, 8'd255);
    random_blocks(n_sent + 300);

    settle();
    set_cfg(8'd2, 8'd4, 8'd6, 8'd8);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_blocks(n_sent + 250);

    settle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_req = 400;
    random_blocks(n_sent + 250);

    settle();
    set_cfg(8'd255, 8'd255, 8'd2, 8'd0);
    long_runs();

    settle();
    set_cfg(8'($urandom_range(8)), 8'($urandom_range(8)), 8'($urandom), 8'($urandom_range(8)));
    random_blocks(n_sent + 450);

    settle();
    repeat (8) @(posedge clk_i);
    $display("%0d words checked, %0d block summaries, %0d cycles", chk.checked,
             chk.summaries, cycle_cnt);
    $display("word classes seen %b, error flags raised %b", chk.classes_seen, chk.flags_seen);
    if (chk.fails == 0 && chk.pending_verdicts.size() == 0) begin
      $display("tdc_readout_word_checker_unit: match");
    end else begin
      $display("tdc_readout_word_checker_unit: mismatch");
    end
    $finish;
  end

endmodule
